// File: src/appmp_pkg.sv
`default_nettype none

package appmp_pkg;

   // Fixed field widths.
   localparam int VAL_BITS      = 16;
   localparam int LIMIT_BITS    = 16;
   localparam int MUL_CNT_BITS  = $clog2(VAL_BITS);
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // Register index is taken from address bit 2.
   localparam logic CSR_IDX_MODULUS    = 1'b0;
   localparam logic CSR_IDX_STEP_LIMIT = 1'b1;

   localparam logic [LIMIT_BITS-1:0] STEP_LIMIT_RESET = '1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SETUP,
      S_EXEC,
      S_MUL,
      S_INIT,
      S_DE,
      S_ABC,
      S_FINISH
   } state_type;

   typedef enum logic [1:0] {
      PH_INIT,
      PH_DE,
      PH_ABC
   } phase_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_QRED,
      OP_QSQ,
      OP_Q4SQ,
      OP_MUL_POLY_Q,
      OP_MUL_MONO_Q,
      OP_MUL_POLY_Q4,
      OP_MUL_MONO_Q4,
      OP_ADD,
      OP_SUB
   } op_type;

endpackage

`default_nettype wire

// File: src/appmp_req_if.sv
`default_nettype none

interface appmp_req_if
   import appmp_pkg::*;
#(
   parameter int COUNT_BITS = 12
);
   logic                  valid;
   logic                  ready;
   logic [COUNT_BITS-1:0] count_a;
   logic [COUNT_BITS-1:0] count_b;
   logic [COUNT_BITS-1:0] count_c;
   logic [COUNT_BITS-1:0] count_d;
   logic [COUNT_BITS-1:0] count_e;
   logic [VAL_BITS-1:0]   eval_point;

   modport source (
      output valid, count_a, count_b, count_c, count_d, count_e, eval_point,
      input  ready
   );

   modport sink (
      input  valid, count_a, count_b, count_c, count_d, count_e, eval_point,
      output ready
   );
endinterface

`default_nettype wire

// File: src/appmp_rsp_if.sv
`default_nettype none

interface appmp_rsp_if
   import appmp_pkg::*;
;
   logic                valid;
   logic                ready;
   logic [VAL_BITS-1:0] pairing_value;
   logic                timed_out;

   modport source (
      output valid, pairing_value, timed_out,
      input  ready
   );

   modport sink (
      input  valid, pairing_value, timed_out,
      output ready
   );
endinterface

`default_nettype wire

// File: src/arc_pairing_poly_mod_p_core.sv
// Evaluates the arc pairing polynomial at q modulo the prime in the modulus
// register, one beat in and one beat out at a time. All modular products go
// through a single shift-and-add multiplier that retires one bit of the
// multiplier operand per cycle. Start-up captures the counts, reduces q and
// forms q^4, and the walk then runs full reflection rounds until it reaches
// the end position or hits the step limit L. The counts, the step limit and
// back-pressure on the output set the time per item. The input is not ready
// while a walk is in progress, but a finished result may wait in the output
// register while the next beat is taken.
`default_nettype none

module arc_pairing_poly_mod_p_core
   import appmp_pkg::*;
#(
   parameter int COUNT_BITS = 12,
   parameter int MOD_BITS   = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   appmp_req_if.sink                     req_bus,
   appmp_rsp_if.source                   rsp_bus,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                          csr_pready
);

   // Positions can drift by up to ten counts per round over the whole limit.
   localparam int XW = COUNT_BITS + LIMIT_BITS + 6;
   localparam int MW = MOD_BITS + 2;

   typedef logic signed [XW-1:0] pos_type;
   typedef logic [MOD_BITS-1:0]  res_type;

   // Configuration registers.
   res_type               modulus_ff, modulus_in;
   logic [LIMIT_BITS-1:0] step_limit_ff, step_limit_in;

   // Sequencer.
   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   op_type    op_ff [3];
   op_type    op_in [3];

   // Item data.
   logic [COUNT_BITS-1:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [COUNT_BITS-1:0] a_in, b_in, c_in, d_in, e_in;
   logic [VAL_BITS-1:0]   eval_ff, eval_in;
   res_type               p_ff, p_in;
   pos_type bl_ff, start_ff, cl_ff, endp_ff, el_ff, er_ff;
   pos_type sa_ff, sb_ff, sc_ff, sd_ff, se_ff;
   pos_type bl_in, start_in, cl_in, endp_in, el_in, er_in;
   pos_type sa_in, sb_in, sc_in, sd_in, se_in;
   pos_type x_ff, x_in;
   logic [LIMIT_BITS-1:0] round_ff, round_in;
   res_type q_ff, q4_ff, poly_ff, mono_ff;
   res_type q_in, q4_in, poly_in, mono_in;
   logic    timeout_ff, timeout_in;

   // Shared modular multiplier.
   res_type               mul_acc_ff, mul_acc_in;
   logic [VAL_BITS-1:0]   mul_x_ff, mul_x_in;
   res_type               mul_y_ff, mul_y_in;
   logic [MUL_CNT_BITS-1:0] mul_cnt_ff, mul_cnt_in;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VAL_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                rsp_tout_ff, rsp_tout_in;

   // Combinational helpers.
   logic    req_fire, csr_write;
   pos_type ext_a, ext_b, ext_c, ext_d, ext_e;
   pos_type de_x, abc_x;
   logic    de_lo, de_inner, de_outer;
   logic    abc_lo, abc_bl, abc_a, abc_start, abc_endp, abc_gt;
   logic    op_is_mul, mul_last, out_free;
   logic [MW-1:0] mul_t, mul_t1, mul_t2, p_wide;
   res_type mul_res;
   logic [MOD_BITS:0] add_s, sub_s;
   res_type add_res, sub_res;
   op_type  de_op0, de_op1, abc_op;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      if (csr_paddr[1:0] != 2'b00) begin
         csr_prdata = '0;
      end else if (csr_paddr[2] == CSR_IDX_MODULUS) begin
         csr_prdata = CSR_DATA_BITS'(modulus_ff);
      end else begin
         csr_prdata = CSR_DATA_BITS'(step_limit_ff);
      end
   end

   always_comb begin
      modulus_in    = modulus_ff;
      step_limit_in = step_limit_ff;
      if (csr_write) begin
         if (csr_paddr[2] == CSR_IDX_MODULUS) begin
            modulus_in = csr_pwdata[MOD_BITS-1:0];
         end else begin
            step_limit_in = csr_pwdata[LIMIT_BITS-1:0];
         end
      end
   end

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.pairing_value = rsp_value_ff;
   assign rsp_bus.timed_out     = rsp_tout_ff;
   assign out_free              = !rsp_valid_ff || rsp_bus.ready;

   assign ext_a = pos_type'(a_ff);
   assign ext_b = pos_type'(b_ff);
   assign ext_c = pos_type'(c_ff);
   assign ext_d = pos_type'(d_ff);
   assign ext_e = pos_type'(e_ff);

   // Decisions for the d/e reflection.
   assign de_lo    = x_ff < el_ff;
   assign de_inner = x_ff < ext_d;
   assign de_outer = x_ff < er_ff;
   assign de_x     = de_lo ? (sd_ff - x_ff) : (se_ff - x_ff);

   always_comb begin
      if (de_lo) begin
         if (de_inner) begin
            de_op0 = OP_MUL_MONO_Q;
            de_op1 = OP_ADD;
         end else begin
            de_op0 = OP_SUB;
            de_op1 = OP_MUL_POLY_Q;
         end
      end else begin
         if (de_outer) begin
            de_op0 = OP_SUB;
            de_op1 = OP_MUL_MONO_Q;
         end else begin
            de_op0 = OP_MUL_POLY_Q;
            de_op1 = OP_ADD;
         end
      end
   end

   // Decisions for the a/b/c reflection.
   assign abc_lo    = x_ff < cl_ff;
   assign abc_bl    = x_ff < bl_ff;
   assign abc_a     = x_ff < ext_a;
   assign abc_start = x_ff < start_ff;
   assign abc_endp  = x_ff < endp_ff;
   assign abc_gt    = x_ff > endp_ff;

   always_comb begin
      if (abc_lo) begin
         if (abc_bl) begin
            abc_op = abc_a ? OP_MUL_POLY_Q : OP_MUL_MONO_Q;
            abc_x  = sa_ff - x_ff;
         end else begin
            abc_op = abc_start ? OP_MUL_MONO_Q4 : OP_MUL_POLY_Q4;
            abc_x  = sb_ff - x_ff;
         end
      end else begin
         abc_op = abc_endp ? OP_MUL_POLY_Q : OP_MUL_MONO_Q;
         abc_x  = sc_ff - x_ff;
      end
   end

   // One multiplier bit per cycle: acc = 2*acc + bit*y, reduced by up to
   // two subtractions since both operands stay at or below p.
   assign p_wide  = MW'(p_ff);
   assign mul_t   = {1'b0, mul_acc_ff, 1'b0}
                    + (mul_x_ff[VAL_BITS-1] ? MW'(mul_y_ff) : MW'(0));
   assign mul_t1  = (mul_t >= p_wide) ? (mul_t - p_wide) : mul_t;
   assign mul_t2  = (mul_t1 >= p_wide) ? (mul_t1 - p_wide) : mul_t1;
   assign mul_res = mul_t2[MOD_BITS-1:0];
   assign mul_last = (mul_cnt_ff == MUL_CNT_BITS'(VAL_BITS - 1));

   assign add_s   = {1'b0, poly_ff} + {1'b0, mono_ff};
   assign add_res = (add_s >= {1'b0, p_ff}) ? res_type'(add_s - {1'b0, p_ff})
                                            : add_s[MOD_BITS-1:0];
   assign sub_s   = {1'b0, poly_ff} + {1'b0, p_ff} - {1'b0, mono_ff};
   assign sub_res = (sub_s >= {1'b0, p_ff}) ? res_type'(sub_s - {1'b0, p_ff})
                                            : sub_s[MOD_BITS-1:0];

   assign op_is_mul = op_ff[0] inside {OP_QRED, OP_QSQ, OP_Q4SQ, OP_MUL_POLY_Q,
                                       OP_MUL_MONO_Q, OP_MUL_POLY_Q4, OP_MUL_MONO_Q4};

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_SETUP;
            end
         end
         S_SETUP: state_in = S_EXEC;
         S_EXEC: begin
            if (op_ff[0] == OP_NONE) begin
               case (phase_ff)
                  PH_INIT: state_in = S_INIT;
                  PH_DE:   state_in = S_ABC;
                  default: state_in = S_DE;
               endcase
            end else if (op_is_mul) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (mul_last) begin
               state_in = S_EXEC;
            end
         end
         S_INIT: state_in = S_DE;
         S_DE: begin
            state_in = (round_ff == step_limit_ff) ? S_FINISH : S_EXEC;
         end
         S_ABC: begin
            state_in = (!abc_lo && !abc_endp && !abc_gt) ? S_FINISH : S_EXEC;
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      phase_in   = phase_ff;
      op_in      = op_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      c_in       = c_ff;
      d_in       = d_ff;
      e_in       = e_ff;
      eval_in    = eval_ff;
      p_in       = p_ff;
      bl_in      = bl_ff;
      start_in   = start_ff;
      cl_in      = cl_ff;
      endp_in    = endp_ff;
      el_in      = el_ff;
      er_in      = er_ff;
      sa_in      = sa_ff;
      sb_in      = sb_ff;
      sc_in      = sc_ff;
      sd_in      = sd_ff;
      se_in      = se_ff;
      x_in       = x_ff;
      round_in   = round_ff;
      q_in       = q_ff;
      q4_in      = q4_ff;
      poly_in    = poly_ff;
      mono_in    = mono_ff;
      timeout_in = timeout_ff;
      mul_acc_in = mul_acc_ff;
      mul_x_in   = mul_x_ff;
      mul_y_in   = mul_y_ff;
      mul_cnt_in = mul_cnt_ff;
      rsp_value_in = rsp_value_ff;
      rsp_tout_in  = rsp_tout_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               a_in    = req_bus.count_a;
               b_in    = req_bus.count_b;
               c_in    = req_bus.count_c;
               d_in    = req_bus.count_d;
               e_in    = req_bus.count_e;
               eval_in = req_bus.eval_point;
               p_in    = (modulus_ff == '0) ? res_type'(1) : modulus_ff;
            end
         end
         S_SETUP: begin
            bl_in    = ext_a + ext_a;
            start_in = ext_a + ext_a + ext_b;
            cl_in    = ext_a + ext_a + ext_b + ext_b + pos_type'(1);
            endp_in  = ext_a + ext_a + ext_b + ext_b + ext_c + pos_type'(1);
            el_in    = ext_d + ext_d;
            er_in    = ext_d + ext_d + ext_e;
            sa_in    = ext_a + ext_a - pos_type'(1);
            sb_in    = ((ext_a + ext_a) <<< 1) + ext_b + ext_b;
            sc_in    = ((ext_a + ext_a + ext_b + ext_b + ext_c) <<< 1) + pos_type'(2);
            sd_in    = ext_d + ext_d - pos_type'(1);
            se_in    = ((ext_d + ext_d + ext_e) <<< 1) - pos_type'(1);
            op_in[0] = OP_QRED;
            op_in[1] = OP_QSQ;
            op_in[2] = OP_Q4SQ;
            phase_in = PH_INIT;
         end
         S_EXEC: begin
            if (op_ff[0] == OP_ADD || op_ff[0] == OP_SUB) begin
               poly_in  = (op_ff[0] == OP_ADD) ? add_res : sub_res;
               op_in[0] = op_ff[1];
               op_in[1] = op_ff[2];
               op_in[2] = OP_NONE;
            end else if (op_is_mul) begin
               mul_acc_in = '0;
               mul_cnt_in = '0;
               case (op_ff[0])
                  OP_QRED: begin
                     mul_x_in = eval_ff;
                     mul_y_in = res_type'(1);
                  end
                  OP_QSQ: begin
                     mul_x_in = VAL_BITS'(q_ff);
                     mul_y_in = q_ff;
                  end
                  OP_Q4SQ: begin
                     mul_x_in = VAL_BITS'(q4_ff);
                     mul_y_in = q4_ff;
                  end
                  OP_MUL_POLY_Q: begin
                     mul_x_in = VAL_BITS'(poly_ff);
                     mul_y_in = q_ff;
                  end
                  OP_MUL_MONO_Q: begin
                     mul_x_in = VAL_BITS'(mono_ff);
                     mul_y_in = q_ff;
                  end
                  OP_MUL_POLY_Q4: begin
                     mul_x_in = VAL_BITS'(poly_ff);
                     mul_y_in = q4_ff;
                  end
                  default: begin
                     mul_x_in = VAL_BITS'(mono_ff);
                     mul_y_in = q4_ff;
                  end
               endcase
            end
         end
         S_MUL: begin
            mul_acc_in = mul_res;
            mul_x_in   = {mul_x_ff[VAL_BITS-2:0], 1'b0};
            mul_cnt_in = mul_cnt_ff + MUL_CNT_BITS'(1);
            if (mul_last) begin
               case (op_ff[0])
                  OP_QRED:                       q_in    = mul_res;
                  OP_QSQ, OP_Q4SQ:               q4_in   = mul_res;
                  OP_MUL_POLY_Q, OP_MUL_POLY_Q4: poly_in = mul_res;
                  default:                       mono_in = mul_res;
               endcase
               op_in[0] = op_ff[1];
               op_in[1] = op_ff[2];
               op_in[2] = OP_NONE;
            end
         end
         S_INIT: begin
            poly_in  = '0;
            mono_in  = (p_ff == res_type'(1)) ? res_type'(0) : res_type'(1);
            x_in     = start_ff;
            round_in = '0;
         end
         S_DE: begin
            if (round_ff == step_limit_ff) begin
               timeout_in = 1'b1;
            end else begin
               x_in     = de_x;
               op_in[0] = de_op0;
               op_in[1] = de_op1;
               op_in[2] = OP_NONE;
               phase_in = PH_DE;
            end
         end
         S_ABC: begin
            if (!abc_lo && !abc_endp && !abc_gt) begin
               timeout_in = 1'b0;
            end else begin
               x_in     = abc_x;
               op_in[0] = abc_op;
               op_in[1] = OP_NONE;
               op_in[2] = OP_NONE;
               phase_in = PH_ABC;
               round_in = round_ff + LIMIT_BITS'(1);
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_tout_in  = timeout_ff;
               rsp_value_in = timeout_ff ? '0 : VAL_BITS'(poly_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff    <= res_type'(2);
         step_limit_ff <= STEP_LIMIT_RESET;
         state_ff      <= S_IDLE;
         phase_ff      <= PH_INIT;
         op_ff[0]      <= OP_NONE;
         op_ff[1]      <= OP_NONE;
         op_ff[2]      <= OP_NONE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         modulus_ff    <= modulus_in;
         step_limit_ff <= step_limit_in;
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         op_ff         <= op_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff       <= a_in;
      b_ff       <= b_in;
      c_ff       <= c_in;
      d_ff       <= d_in;
      e_ff       <= e_in;
      eval_ff    <= eval_in;
      p_ff       <= p_in;
      bl_ff      <= bl_in;
      start_ff   <= start_in;
      cl_ff      <= cl_in;
      endp_ff    <= endp_in;
      el_ff      <= el_in;
      er_ff      <= er_in;
      sa_ff      <= sa_in;
      sb_ff      <= sb_in;
      sc_ff      <= sc_in;
      sd_ff      <= sd_in;
      se_ff      <= se_in;
      x_ff       <= x_in;
      round_ff   <= round_in;
      q_ff       <= q_in;
      q4_ff      <= q4_in;
      poly_ff    <= poly_in;
      mono_ff    <= mono_in;
      timeout_ff <= timeout_in;
      mul_acc_ff <= mul_acc_in;
      mul_x_ff   <= mul_x_in;
      mul_y_ff   <= mul_y_in;
      mul_cnt_ff <= mul_cnt_in;
      rsp_value_ff <= rsp_value_in;
      rsp_tout_ff  <= rsp_tout_in;
   end

endmodule

`default_nettype wire

// File: src/appmp_checker.sv
`default_nettype none

module appmp_checker
   import appmp_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [VAL_BITS-1:0] pairing_value,
   input wire logic                timed_out
);

   // A walk is in progress after every accepted beat.
   a_busy_after_accept: assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready
   ) else $error("input still ready right after an accepted beat");

   // A result never appears in the cycle after a beat is taken.
   a_no_instant_result: assert property (
      @(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready)
   ) else $error("result raised straight after an input beat");

   a_timeout_value_zero: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && timed_out) |-> (pairing_value == '0)
   ) else $error("timed-out result carries a non-zero value");

   a_rsp_hold: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(pairing_value) && $stable(timed_out))
   ) else $error("stalled result beat changed or dropped");

endmodule

bind arc_pairing_poly_mod_p_core appmp_checker u_appmp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .pairing_value (rsp_bus.pairing_value),
   .timed_out     (rsp_bus.timed_out)
);

`default_nettype wire
